// ===== rtl/core/lpc_pkg.sv =====
// Package for the LRU page cache control: command, kind and status codes.
// Used by lpc_cell and lru_page_cache_with_free_list.
package lpc_pkg;
  localparam int unsigned CacheWaysDef = 16;
  localparam int unsigned MaxPagesDef  = 4096;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_ALLOC = 3'd2;
  localparam logic [2:0] CMD_FREE  = 3'd3;
  localparam logic [2:0] CMD_ROOT  = 3'd4;
  localparam logic [2:0] CMD_FLUSH = 3'd5;

  localparam logic [1:0] KIND_UNCLEAN = 2'd0;
  localparam logic [1:0] KIND_WB      = 2'd1;
  localparam logic [1:0] KIND_CLEAN   = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // per-cell control, one beat to the whole row
  typedef struct packed {
    logic shift;   // take the neighbour's entry
    logic load;    // take the head entry
    logic clean;   // clear dirty mark
    logic kill;    // clear valid
  } cell_ctl_t;
endpackage

// ===== rtl/core/lpc_ram.sv =====
// Generic RAM with one write port and one read port, registered read.
// No dependencies.
module lpc_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/lpc_cell.sv =====
// One recency cell: page id, dirty and valid mark; shifts from its neighbour.
// Depends on lpc_pkg.
module lpc_cell #(
  parameter int unsigned PW = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lpc_pkg::cell_ctl_t ctl,
  input  logic [PW-1:0]      prev_page,
  input  logic               prev_dirty,
  input  logic               prev_valid,
  input  logic [PW-1:0]      head_page,
  input  logic               head_dirty,
  input  logic [PW-1:0]      key,
  output logic [PW-1:0]      page,
  output logic               dirty,
  output logic               valid,
  output logic               match
);
  import lpc_pkg::*;

  logic [PW-1:0] page_r;
  logic          dirty_r, valid_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      page_r <= head_page;
    end else if (ctl.shift) begin
      page_r <= prev_page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b0;
      valid_r <= 1'b0;
    end else if (ctl.kill) begin
      dirty_r <= 1'b0;
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      dirty_r <= head_dirty;
      valid_r <= 1'b1;
    end else if (ctl.shift) begin
      dirty_r <= prev_dirty;
      valid_r <= prev_valid;
    end else if (ctl.clean) begin
      dirty_r <= 1'b0;
    end
  end

  assign page  = page_r;
  assign dirty = dirty_r;
  assign valid = valid_r;
  assign match = valid_r && (page_r == key);
endmodule

// ===== rtl/core/lru_page_cache_with_free_list.sv =====
// LRU write-back page cache control with page allocator and free list.
// One command in flight; result beats wait on out_ready, and a flush walks the
// cache entries in use (at least one), writing back each dirty one.
// Reset (rst_n, synchronous) empties the cache, page count 1, capacity 16.
module lru_page_cache_with_free_list #(
  parameter int unsigned CACHE_WAYS = lpc_pkg::CacheWaysDef,
  parameter int unsigned MAX_PAGES  = lpc_pkg::MaxPagesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_page_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [11:0] out_page,
  output logic [1:0]  out_status,
  output logic        out_hit,
  output logic        out_fill_needed,
  output logic [31:0] out_root_page,
  output logic [11:0] out_free_head,
  output logic [12:0] out_page_count,
  output logic        out_last
);
  import lpc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PAGES);
  localparam int unsigned CW = $clog2(CACHE_WAYS + 1);
  localparam int unsigned IW = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
  localparam int unsigned NW = $clog2(MAX_PAGES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_HDR   = 4'd2;
  localparam logic [3:0] S_LINK  = 4'd3;
  localparam logic [3:0] S_FIND  = 4'd4;
  localparam logic [3:0] S_EVICT = 4'd5;
  localparam logic [3:0] S_MOVE  = 4'd6;
  localparam logic [3:0] S_FLUSH = 4'd7;
  localparam logic [3:0] S_CLEAN = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [4:0]    cap_r;
  logic [2:0]    cmd_r;
  logic [31:0]   id_r;
  logic [AW-1:0] key_r;
  logic [CW-1:0] count_r;
  logic [NW-1:0] pages_r;
  logic [31:0]   root_r;
  logic [AW-1:0] head_r;
  logic          unclean_r;
  logic [IW-1:0] walk_r;
  logic          hit_r;
  logic          bad_r;
  logic [AW-1:0] page_out_r;
  logic [1:0]    st_r;
  logic          fill_r;

  logic          ov_r;
  logic [1:0]    okind_r;
  logic [11:0]   opage_r;
  logic [1:0]    ost_r;
  logic          ohit_r, ofill_r, olast_r;
  logic [31:0]   oroot_r;
  logic [11:0]   ohead_r;
  logic [12:0]   ocount_r;

  // cell row
  cell_ctl_t     ctl [CACHE_WAYS];
  logic [AW-1:0] c_page  [CACHE_WAYS];
  logic          c_dirty [CACHE_WAYS];
  logic          c_valid [CACHE_WAYS];
  logic [CACHE_WAYS-1:0] c_match;
  logic [AW-1:0] head_page;
  logic          head_dirty;

  // free link store
  logic          ram_we;
  logic [AW-1:0] ram_rd;

  lpc_ram #(.WIDTH(AW), .DEPTH(MAX_PAGES)) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (key_r),
    .wdata (head_r),
    .raddr (head_r),
    .rdata (ram_rd)
  );

  for (genvar g = 0; g < CACHE_WAYS; g++) begin : g_cell
    if (g == 0) begin : g_first
      lpc_cell #(.PW(AW)) u_cell (
        .clk, .rst_n, .ctl(ctl[g]),
        .prev_page('0), .prev_dirty(1'b0), .prev_valid(1'b0),
        .head_page, .head_dirty, .key(key_r),
        .page(c_page[g]), .dirty(c_dirty[g]), .valid(c_valid[g]),
        .match(c_match[g])
      );
    end else begin : g_rest
      lpc_cell #(.PW(AW)) u_cell (
        .clk, .rst_n, .ctl(ctl[g]),
        .prev_page(c_page[g-1]), .prev_dirty(c_dirty[g-1]),
        .prev_valid(c_valid[g-1]),
        .head_page, .head_dirty, .key(key_r),
        .page(c_page[g]), .dirty(c_dirty[g]), .valid(c_valid[g]),
        .match(c_match[g])
      );
    end
  end

  // match position: found flag and index, registered
  logic          found_r;
  logic [IW-1:0] fidx_r;
  logic          found_c;
  logic [IW-1:0] fidx_c;

  always_comb begin
    found_c = 1'b0;
    fidx_c  = '0;
    for (int k = CACHE_WAYS - 1; k >= 0; k--) begin
      if (c_match[k]) begin
        found_c = 1'b1;
        fidx_c  = IW'(k);
      end
    end
  end

  logic [CW-1:0] cap_eff;
  always_comb begin
    if (cap_r == 5'd0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_r) > CACHE_WAYS) begin
      cap_eff = CW'(CACHE_WAYS);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  logic [IW-1:0] last_idx;
  logic          out_free;

  assign last_idx = IW'(count_r - CW'(1));
  assign out_free = !ov_r || out_ready;
  assign head_page = key_r;
  assign head_dirty = (cmd_r == CMD_WRITE || cmd_r == CMD_FREE)
                      || (found_r && c_dirty[fidx_r]);

  // emit request
  logic          emit;
  logic [1:0]    e_kind;
  logic [AW-1:0] e_page;

  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    e_kind    = KIND_DONE;
    e_page    = '0;
    ram_we    = 1'b0;
    for (int k = 0; k < CACHE_WAYS; k++) begin
      ctl[k] = '0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (bad_r) begin
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_FLUSH) begin
          state_nxt = S_FLUSH;
        end else if (cmd_r == CMD_READ || cmd_r > CMD_FLUSH) begin
          state_nxt = (cmd_r == CMD_READ) ? S_FIND : S_DONE;
        end else begin
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (!unclean_r) begin
          emit   = 1'b1;
          e_kind = KIND_UNCLEAN;
        end
        if (unclean_r || out_free) begin
          if (cmd_r == CMD_ROOT) begin
            state_nxt = S_DONE;
          end else if (cmd_r == CMD_ALLOC) begin
            state_nxt = (head_r != '0) ? S_LINK : S_DONE;
          end else begin
            state_nxt = S_FIND;
          end
        end
      end
      S_LINK: begin
        state_nxt = S_FIND;
      end
      S_FIND: begin
        state_nxt = found_c ? S_MOVE : S_EVICT;
      end
      S_EVICT: begin
        if (count_r >= cap_eff && count_r != '0) begin
          emit   = c_dirty[last_idx];
          e_kind = KIND_WB;
          e_page = c_page[last_idx];
          if (!c_dirty[last_idx] || out_free) begin
            ctl[last_idx].kill = 1'b1;
          end
        end else begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        for (int k = 0; k < CACHE_WAYS; k++) begin
          if (k == 0) begin
            ctl[k].load = 1'b1;
          end else if (found_r ? (IW'(k) <= fidx_r) : (CW'(k) <= count_r)) begin
            ctl[k].shift = 1'b1;
          end
        end
        ram_we    = (cmd_r == CMD_FREE);
        state_nxt = S_DONE;
      end
      S_FLUSH: begin
        if (CW'(walk_r) < count_r && c_dirty[walk_r]) begin
          emit   = 1'b1;
          e_kind = KIND_WB;
          e_page = c_page[walk_r];
          if (out_free) begin
            ctl[walk_r].clean = 1'b1;
          end
        end
        if ((!(CW'(walk_r) < count_r && c_dirty[walk_r]) || out_free)
            && (32'(walk_r) == CACHE_WAYS - 1 || CW'(walk_r) + CW'(1) >= count_r)) begin
          state_nxt = S_CLEAN;
        end
      end
      S_CLEAN: begin
        emit   = 1'b1;
        e_kind = KIND_CLEAN;
        if (out_free) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        emit   = 1'b1;
        e_kind = KIND_DONE;
        e_page = page_out_r;
        if (out_free) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cap_r     <= 5'd16;
      count_r   <= '0;
      pages_r   <= NW'(1);
      root_r    <= '0;
      head_r    <= '0;
      unclean_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (emit && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (state_r == S_HDR && !unclean_r && out_free) begin
        unclean_r <= 1'b1;
      end
      if (state_r == S_CLEAN && out_free) begin
        unclean_r <= 1'b0;
      end
      if (state_r == S_HDR && cmd_r == CMD_ROOT && (unclean_r || out_free)) begin
        root_r <= id_r;
      end
      if (state_r == S_HDR && cmd_r == CMD_ALLOC && head_r == '0
          && (unclean_r || out_free) && pages_r < NW'(MAX_PAGES)) begin
        pages_r <= pages_r + NW'(1);
      end
      if (state_r == S_LINK) begin
        head_r <= ram_rd;
      end
      if (state_r == S_EVICT && count_r >= cap_eff && count_r != '0
          && (!c_dirty[last_idx] || out_free)) begin
        count_r <= count_r - CW'(1);
      end
      if (state_r == S_MOVE && !found_r) begin
        count_r <= count_r + CW'(1);
      end
      if (state_r == S_MOVE && cmd_r == CMD_FREE) begin
        head_r <= key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      cmd_r  <= in_command;
      id_r   <= in_page_id;
      key_r  <= AW'(in_page_id);
      bad_r  <= (in_command == CMD_READ || in_command == CMD_WRITE
                 || in_command == CMD_FREE)
                && (in_page_id == 32'd0 || in_page_id >= 32'(pages_r));
      walk_r <= '0;
      hit_r  <= 1'b0;
      fill_r <= 1'b0;
      st_r   <= ST_OK;
      page_out_r <= '0;
    end
    if (state_r == S_CHECK) begin
      if (bad_r) begin
        st_r <= ST_RANGE;
      end else if (cmd_r == CMD_READ || cmd_r == CMD_WRITE || cmd_r == CMD_FREE) begin
        page_out_r <= key_r;
      end
    end
    if (state_r == S_HDR && cmd_r == CMD_ALLOC && (unclean_r || out_free)) begin
      if (head_r != '0) begin
        key_r      <= head_r;
        page_out_r <= head_r;
      end else if (pages_r >= NW'(MAX_PAGES)) begin
        st_r <= ST_FULL;
      end else begin
        page_out_r <= AW'(pages_r);
      end
    end
    if (state_r == S_FIND) begin
      found_r <= found_c;
      fidx_r  <= fidx_c;
      hit_r   <= found_c;
      fill_r  <= !found_c && cmd_r != CMD_WRITE && cmd_r != CMD_FREE;
    end
    if (state_r == S_FLUSH && ((!(CW'(walk_r) < count_r && c_dirty[walk_r])) || out_free)
        && 32'(walk_r) < CACHE_WAYS - 1) begin
      walk_r <= walk_r + IW'(1);
    end
    if (emit && out_free) begin
      okind_r  <= e_kind;
      opage_r  <= 12'(e_page);
      ost_r    <= (e_kind == KIND_DONE) ? st_r : ST_OK;
      ohit_r   <= (e_kind == KIND_DONE) && hit_r;
      ofill_r  <= (e_kind == KIND_DONE) && fill_r;
      olast_r  <= (e_kind == KIND_DONE);
      oroot_r  <= (e_kind == KIND_UNCLEAN || e_kind == KIND_CLEAN) ? root_r : '0;
      ohead_r  <= (e_kind == KIND_UNCLEAN || e_kind == KIND_CLEAN) ? 12'(head_r) : '0;
      ocount_r <= (e_kind == KIND_UNCLEAN || e_kind == KIND_CLEAN) ? 13'(pages_r) : '0;
    end
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_page        = opage_r;
  assign out_status      = ost_r;
  assign out_hit         = ohit_r;
  assign out_fill_needed = ofill_r;
  assign out_root_page   = oroot_r;
  assign out_free_head   = ohead_r;
  assign out_page_count  = ocount_r;
  assign out_last        = olast_r;
endmodule
